### rtl/chm_pkg.sv
// Shared types and constants for the chained hash map block.
package chm_pkg;

  localparam int unsigned BUCKETS_DEF = 64;
  localparam int unsigned WAYS_DEF    = 8;
  localparam int unsigned KEY_W       = 64;
  localparam int unsigned VAL_W       = 64;
  localparam int unsigned FILL_W      = 4;
  // Key bits folded into the bucket remainder per cycle.
  localparam int unsigned MOD_DIGIT   = 8;
  localparam int unsigned MOD_DIGITS  = KEY_W / MOD_DIGIT;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef struct packed {
    logic             opcode;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value_in;
  } chm_req_t;

  typedef struct packed {
    logic             found;
    logic [VAL_W-1:0] value_out;
    logic             status;
  } chm_rsp_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } chm_entry_t;

  typedef struct packed {
    logic clr;
    logic mod_start;
    logic mod_step;
    logic fill_rd;
    logic search;
  } chm_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic mod_last;
    logic hit;
    logic miss;
  } chm_sts_t;

endpackage

### rtl/chained_hash_map_insert_lookup.sv
// Top level of the chained hash map: insert-or-replace and lookup of 64-bit keys.
// A request is taken when start is high and busy is low; its single result appears
// on rsp_o for one cycle with done_o high, and must be captured then. After reset
// the block clears the per-bucket fill counts, busy high. Each request then passes
// from acceptance to the next possible acceptance through an accept cycle, the
// reduction of the key modulo BUCKETS (eight key bits per cycle), a fill-count
// read, and the search of the bucket in the entry memory, which is read once per
// cycle; the search ends on a hit, or on a miss once every filled way has been read.
// The result strobe falls in the first cycle in which a new request may be
// accepted.
module chained_hash_map_insert_lookup #(
  parameter int unsigned BUCKETS = chm_pkg::BUCKETS_DEF,
  parameter int unsigned WAYS    = chm_pkg::WAYS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  chm_pkg::chm_req_t req_i,
  output logic              done_o,
  output chm_pkg::chm_rsp_t rsp_o
);

  chm_pkg::chm_cmd_t cmd;
  chm_pkg::chm_sts_t sts;

  chm_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .cmd_o  (cmd),
    .sts_i  (sts)
  );

  chm_dp #(
    .BUCKETS (BUCKETS),
    .WAYS    (WAYS)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .rsp_o  (rsp_o)
  );

endmodule

### rtl/chm_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module chm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/chm_ctrl.sv
// Controller state machine sequencing clear, bucket reduction, fill read and search.
module chm_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  output logic              done_o,
  output chm_pkg::chm_cmd_t cmd_o,
  input  chm_pkg::chm_sts_t sts_i
);

  typedef enum logic [4:0] {
    S_CLEAR  = 5'b00001,
    S_IDLE   = 5'b00010,
    S_MOD    = 5'b00100,
    S_FILL   = 5'b01000,
    S_SEARCH = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   done_q, done_d;

  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start) state_d = S_MOD;
      end
      S_MOD: begin
        if (sts_i.mod_last) state_d = S_FILL;
      end
      S_FILL: begin
        state_d = S_SEARCH;
      end
      S_SEARCH: begin
        if (sts_i.hit || sts_i.miss) begin
          state_d = S_IDLE;
          done_d  = 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  assign busy             = (state_q != S_IDLE);
  assign done_o           = done_q;
  assign cmd_o.clr        = (state_q == S_CLEAR);
  assign cmd_o.mod_start  = (state_q == S_IDLE) && start;
  assign cmd_o.mod_step   = (state_q == S_MOD);
  assign cmd_o.fill_rd    = (state_q == S_FILL);
  assign cmd_o.search     = (state_q == S_SEARCH);

endmodule

### rtl/chm_dp.sv
// Datapath: bucket remainder unit, fill-count and entry memories, bucket search.
module chm_dp #(
  parameter int unsigned BUCKETS = chm_pkg::BUCKETS_DEF,
  parameter int unsigned WAYS    = chm_pkg::WAYS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  chm_pkg::chm_req_t req_i,
  input  chm_pkg::chm_cmd_t cmd_i,
  output chm_pkg::chm_sts_t sts_o,
  output chm_pkg::chm_rsp_t rsp_o
);

  localparam int unsigned BW    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int unsigned SLOTS = BUCKETS * WAYS;
  localparam int unsigned AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned WW    = $clog2(WAYS + 1);
  localparam int unsigned DCW   =
    (chm_pkg::MOD_DIGITS > 1) ? $clog2(chm_pkg::MOD_DIGITS) : 1;
  localparam int unsigned EW    = chm_pkg::KEY_W + chm_pkg::VAL_W;

  chm_pkg::chm_req_t        req_q;
  logic [chm_pkg::KEY_W-1:0] key_sh_q;
  logic [BW-1:0]            rem_q, rem_d;
  logic [DCW-1:0]           dig_cnt_q;
  logic [AW-1:0]            base_q;
  logic [WW-1:0]            rd_way_q;
  logic                     pend_q;
  logic [AW-1:0]            cmp_slot_q;
  logic [BW-1:0]            clr_idx_q;
  chm_pkg::chm_rsp_t        rsp_q;

  logic [BW:0]              mod_t;
  logic [BW-1:0]            mod_r;

  logic [chm_pkg::FILL_W-1:0] fill_raw;
  logic [WW-1:0]              fill_w;
  logic [EW-1:0]              ent_rdata;
  chm_pkg::chm_entry_t        ent;
  logic                       match, at_end, hit, miss, room, is_insert, issue;
  logic                       append;

  logic                       ent_we;
  logic [AW-1:0]              ent_waddr, ent_raddr;
  chm_pkg::chm_entry_t        ent_wdata;
  logic                       fill_we;
  logic [BW-1:0]              fill_waddr;
  logic [chm_pkg::FILL_W-1:0] fill_wdata;

  // Remainder of the key by the bucket count, MOD_DIGIT key bits per cycle from the top.
  always_comb begin
    mod_r = rem_q;
    mod_t = '0;
    for (int i = 0; i < chm_pkg::MOD_DIGIT; i++) begin
      mod_t = {mod_r, key_sh_q[chm_pkg::KEY_W-1-i]};
      if (mod_t >= (BW+1)'(BUCKETS)) begin
        mod_t = mod_t - (BW+1)'(BUCKETS);
      end
      mod_r = mod_t[BW-1:0];
    end
    rem_d = mod_r;
  end

  // Fill counts never exceed the way count, but clamp them as the search bound.
  assign fill_w = (fill_raw > chm_pkg::FILL_W'(WAYS)) ? WW'(WAYS) : fill_raw[WW-1:0];
  assign ent    = chm_pkg::chm_entry_t'(ent_rdata);

  assign is_insert = (req_q.opcode == chm_pkg::OP_INSERT);
  assign match     = pend_q && (ent.key == req_q.key);
  assign at_end    = (rd_way_q == fill_w);
  assign hit       = cmd_i.search && match;
  assign miss      = cmd_i.search && !match && at_end;
  assign issue     = cmd_i.search && !match && !at_end;
  assign room      = (fill_w != WW'(WAYS));
  assign append    = miss && is_insert && room;

  assign ent_raddr       = base_q + AW'(rd_way_q);
  assign ent_we          = (hit && is_insert) || append;
  assign ent_waddr       = hit ? cmp_slot_q : (base_q + AW'(fill_w));
  assign ent_wdata.key   = req_q.key;
  assign ent_wdata.value = req_q.value_in;

  assign fill_we    = cmd_i.clr || append;
  assign fill_waddr = cmd_i.clr ? clr_idx_q : rem_q;
  assign fill_wdata = cmd_i.clr ? '0 : (fill_raw + chm_pkg::FILL_W'(1));

  chm_ram #(
    .WIDTH (chm_pkg::FILL_W),
    .DEPTH (BUCKETS)
  ) u_fill_ram (
    .clk_i   (clk_i),
    .we_i    (fill_we),
    .waddr_i (fill_waddr),
    .wdata_i (fill_wdata),
    .re_i    (cmd_i.fill_rd),
    .raddr_i (rem_q),
    .rdata_o (fill_raw)
  );

  chm_ram #(
    .WIDTH (EW),
    .DEPTH (SLOTS)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (ent_waddr),
    .wdata_i (ent_wdata),
    .re_i    (issue),
    .raddr_i (ent_raddr),
    .rdata_o (ent_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_idx_q <= '0;
      dig_cnt_q <= '0;
      rd_way_q  <= '0;
      pend_q    <= 1'b0;
    end else begin
      if (cmd_i.clr) begin
        clr_idx_q <= clr_idx_q + BW'(1);
      end
      if (cmd_i.mod_start) begin
        dig_cnt_q <= '0;
        rd_way_q  <= '0;
        pend_q    <= 1'b0;
      end else begin
        if (cmd_i.mod_step) begin
          dig_cnt_q <= dig_cnt_q + DCW'(1);
        end
        if (issue) begin
          rd_way_q <= rd_way_q + WW'(1);
          pend_q   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mod_start) begin
      req_q    <= req_i;
      key_sh_q <= req_i.key;
      rem_q    <= '0;
    end else if (cmd_i.mod_step) begin
      key_sh_q <= key_sh_q << chm_pkg::MOD_DIGIT;
      rem_q    <= rem_d;
    end
    if (cmd_i.fill_rd) begin
      base_q <= AW'(rem_q) * AW'(WAYS);
    end
    if (issue) begin
      cmp_slot_q <= ent_raddr;
    end
    if (hit || miss) begin
      rsp_q.found     <= hit;
      rsp_q.value_out <= hit ? ent.value : '0;
      rsp_q.status    <= (miss && is_insert && !room) ? chm_pkg::STATUS_FULL
                                                      : chm_pkg::STATUS_OK;
    end
  end

  assign sts_o.clr_last = (clr_idx_q == BW'(BUCKETS - 1));
  assign sts_o.mod_last = (dig_cnt_q == DCW'(chm_pkg::MOD_DIGITS - 1));
  assign sts_o.hit      = hit;
  assign sts_o.miss     = miss;
  assign rsp_o          = rsp_q;

endmodule

### tb/sv/tb_chained_hash_map_insert_lookup.sv
// Self-checking testbench for the chained hash map: predicted results against strobed outputs.
module tb_chained_hash_map_insert_lookup;
  import chm_pkg::*;

  localparam int unsigned NB          = BUCKETS_DEF;
  localparam int unsigned NW          = WAYS_DEF;
  localparam int unsigned BIDX_W      = $clog2(NB);
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned TAIL_CYCLES = 40;
  localparam int unsigned IDLE_PCT    = 30;
  localparam int unsigned PHASES      = 4;
  localparam int unsigned PHASE_ITEMS = 320;

  typedef struct {
    chm_req_t req;
    bit       drain;
  } pending_req_t;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  chm_req_t req_i = '0;
  logic     done_o;
  chm_rsp_t rsp_o;

  chained_hash_map_insert_lookup dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow copy of the table.
  logic [KEY_W-1:0] shadow_key [NB*NW];
  logic [VAL_W-1:0] shadow_val [NB*NW];
  int unsigned      shadow_fill [NB];

  pending_req_t req_backlog_q[$];
  chm_rsp_t     expected_rsp_q[$];
  int unsigned  total_reqs;
  int unsigned  accepted_cnt;
  int unsigned  in_flight;
  int unsigned  mismatch_cnt = 0;
  int unsigned  cycle_cnt = 0;
  bit           drv_took;
  int unsigned  drv_next_in_flight;
  pending_req_t drv_pick;

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [KEY_W-1:0] key_in_bucket(int unsigned b);
    logic [KEY_W-1:0] k;
    k = rand64();
    k[BIDX_W-1:0] = b[BIDX_W-1:0];
    return k;
  endfunction

  // Applies one request to the shadow table and returns the result it should give.
  function automatic chm_rsp_t apply_to_table(chm_req_t r);
    chm_rsp_t    rsp;
    int unsigned b;
    int unsigned n;
    int          hit_slot;
    rsp = '0;
    rsp.status = STATUS_OK;
    b = int'(r.key % NB);
    n = (shadow_fill[b] > NW) ? NW : shadow_fill[b];
    hit_slot = -1;
    for (int unsigned i = 0; i < n; i++) begin
      if (hit_slot < 0 && shadow_key[b*NW+i] == r.key) hit_slot = b*NW + i;
    end
    if (hit_slot >= 0) begin
      rsp.found = 1'b1;
      rsp.value_out = shadow_val[hit_slot];
      if (r.opcode == OP_INSERT) shadow_val[hit_slot] = r.value_in;
    end else if (r.opcode == OP_INSERT) begin
      if (n >= NW) begin
        rsp.status = STATUS_FULL;
      end else begin
        shadow_key[b*NW+n] = r.key;
        shadow_val[b*NW+n] = r.value_in;
        shadow_fill[b] = n + 1;
      end
    end
    return rsp;
  endfunction

  task automatic note_mismatch(string what);
    $display("mismatch at cycle %0d: %s", cycle_cnt, what);
    mismatch_cnt++;
  endtask

  task automatic queue_req(logic op, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v, bit drain);
    pending_req_t p;
    p.req.opcode = op;
    p.req.key = k;
    p.req.value_in = v;
    p.drain = drain;
    req_backlog_q.push_back(p);
  endtask

  // Sender: a request is held until accepted; new ones go out after random idle cycles.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
      req_i <= '0;
      in_flight <= 0;
      accepted_cnt <= 0;
    end else begin
      drv_took = start && !busy;
      if (drv_took) begin
        expected_rsp_q.push_back(apply_to_table(req_i));
        accepted_cnt <= accepted_cnt + 1;
      end
      drv_next_in_flight = in_flight + (drv_took ? 1 : 0) - (done_o ? 1 : 0);
      in_flight <= drv_next_in_flight;
      if (start && !drv_took) begin
        // Still waiting for the block to take the current request.
      end else if (req_backlog_q.size() != 0
                   && !(req_backlog_q[0].drain && drv_next_in_flight != 0)
                   && ((accepted_cnt >= 600 && accepted_cnt < 900)
                       || $urandom_range(99) >= IDLE_PCT)) begin
        drv_pick = req_backlog_q.pop_front();
        start <= 1'b1;
        req_i <= drv_pick.req;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Receiver: every strobed result is checked against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (expected_rsp_q.size() == 0) begin
        note_mismatch("result with no request outstanding");
      end else begin
        chm_rsp_t exp_rsp;
        exp_rsp = expected_rsp_q.pop_front();
        if (rsp_o.found !== exp_rsp.found)
          note_mismatch($sformatf("found %b, expected %b", rsp_o.found, exp_rsp.found));
        if (rsp_o.value_out !== exp_rsp.value_out)
          note_mismatch($sformatf("value_out %h, expected %h",
                                  rsp_o.value_out, exp_rsp.value_out));
        if (rsp_o.status !== exp_rsp.status)
          note_mismatch($sformatf("status %b, expected %b", rsp_o.status, exp_rsp.status));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("tb_chained_hash_map_insert_lookup failed");
      $finish;
    end
  end

  initial begin
    logic [KEY_W-1:0] b5_keys [NW+1];
    logic [KEY_W-1:0] pool [$];
    int unsigned      hot [$];
    int unsigned      pool_size;
    int unsigned      hot_cnt;
    logic [KEY_W-1:0] k;
    logic             op;

    for (int unsigned i = 0; i < NB; i++) shadow_fill[i] = 0;

    // Directed part: extreme keys and values, hits in the first and last way, a full bucket.
    queue_req(OP_LOOKUP, '0, '1, 1'b0);
    queue_req(OP_INSERT, '0, '1, 1'b0);
    queue_req(OP_LOOKUP, '0, '0, 1'b0);
    queue_req(OP_INSERT, '1, '0, 1'b0);
    queue_req(OP_INSERT, '0, 64'h0123_4567_89ab_cdef, 1'b0);
    for (int unsigned i = 0; i <= NW; i++) b5_keys[i] = key_in_bucket(5);
    for (int unsigned i = 0; i < NW; i++) queue_req(OP_INSERT, b5_keys[i], rand64(), i == 0);
    queue_req(OP_INSERT, b5_keys[NW], rand64(), 1'b0);
    queue_req(OP_LOOKUP, b5_keys[NW], rand64(), 1'b0);
    queue_req(OP_LOOKUP, b5_keys[NW-1], '0, 1'b0);
    queue_req(OP_INSERT, b5_keys[0], '1, 1'b0);
    queue_req(OP_LOOKUP, b5_keys[0], '1, 1'b0);
    queue_req(OP_LOOKUP, b5_keys[3], '1, 1'b0);
    queue_req(OP_LOOKUP, '1, '1, 1'b0);
    queue_req(OP_LOOKUP, 64'h8000_0000_0000_0000, '0, 1'b0);

    // Random phases: keys mostly drawn from a pool crowded into a few buckets, so that
    // replacements, lookup hits and full buckets are common; later phases spread wider.
    for (int unsigned p = 0; p < PHASES; p++) begin
      pool.delete();
      hot.delete();
      case (p)
        0: begin hot_cnt = 1;  pool_size = 14;  end
        1: begin hot_cnt = 3;  pool_size = 32;  end
        2: begin hot_cnt = 8;  pool_size = 70;  end
        default: begin hot_cnt = NB; pool_size = 260; end
      endcase
      for (int unsigned i = 0; i < hot_cnt; i++) hot.push_back($urandom_range(NB-1));
      for (int unsigned i = 0; i < pool_size; i++)
        pool.push_back(key_in_bucket(hot[$urandom_range(hot_cnt-1)]));
      for (int unsigned i = 0; i < PHASE_ITEMS; i++) begin
        op = ($urandom_range(99) < 50) ? OP_INSERT : OP_LOOKUP;
        k = ($urandom_range(99) < 85) ? pool[$urandom_range(pool_size-1)] : rand64();
        queue_req(op, k, rand64(), i == 0);
      end
    end
    total_reqs = req_backlog_q.size();

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (accepted_cnt != total_reqs || in_flight != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (expected_rsp_q.size() != 0)
      note_mismatch($sformatf("%0d results never arrived", expected_rsp_q.size()));
    if (mismatch_cnt == 0) begin
      $display("tb_chained_hash_map_insert_lookup passed");
    end else begin
      $display("tb_chained_hash_map_insert_lookup failed");
    end
    $finish;
  end

endmodule

### chained_hash_map_insert_lookup.f
rtl/chm_pkg.sv
rtl/chm_ram.sv
rtl/chm_ctrl.sv
rtl/chm_dp.sv
rtl/chained_hash_map_insert_lookup.sv
tb/sv/tb_chained_hash_map_insert_lookup.sv
